@@ design/sparse_set_index_manager_macros.svh @@
// Assertion macros for the sparse set index manager.
`ifndef SPARSE_SET_INDEX_MANAGER_MACROS_SVH
`define SPARSE_SET_INDEX_MANAGER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SSIM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SSIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ssim_pkg.sv @@
// Types and constants of the sparse set index manager.
package ssim_pkg;

  localparam int ENTITY_W         = 10;
  localparam int COUNT_W          = 11;
  localparam int ID_SPACE         = 1 << ENTITY_W;
  localparam int MAX_ENTITIES_DEF = 1024;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_GET    = 2'd1,
    FN_HAS    = 2'd2,
    FN_REMOVE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_FIX,
    ST_OUT
  } state_e;

  typedef struct packed {
    func_e               func;
    logic [ENTITY_W-1:0] entity_id;
  } req_t;

  typedef struct packed {
    logic                present;
    logic [ENTITY_W-1:0] dense_index;
    logic                moved;
    logic [ENTITY_W-1:0] moved_from_index;
    logic [ENTITY_W-1:0] moved_entity;
    logic [COUNT_W-1:0]  live_count;
  } rsp_t;

endpackage

@@ design/ssim_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module ssim_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sparse_set_index_manager.sv @@
// Sparse set index manager: maps entity ids to packed dense slots.
//
// Requests arrive on the in channel (valid/ready), each item carrying an
// operation (add, get, has, remove) and an entity id. Every request gives
// exactly one result item on the out channel (valid/ready).
// Each item goes through accept with the reads of both tables, look-up
// and first writes, a second sparse-table write for the swap-remove, and
// the load of the output register. The single write port of the sparse
// table is why the swap-remove needs that second write step.
// After reset the sparse table is swept clear, one entry a cycle, over all
// its entries (1024 by default); in_ready_o stays low meanwhile. The dense
// table is not cleared.
// A result waits in the output register while the receiver stalls; a new
// request is still accepted and worked on, and stalls only when its own
// result is ready to leave while the previous one has not been taken.
// A remove reports the relocation of the last slot so that an outside
// payload store can copy the matching record.
`include "sparse_set_index_manager_macros.svh"

module sparse_set_index_manager #(
  parameter int MAX_ENTITIES = ssim_pkg::MAX_ENTITIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ssim_pkg::req_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ssim_pkg::rsp_t out_item_o
);

  import ssim_pkg::*;

  localparam int Depth = (MAX_ENTITIES < ID_SPACE) ? MAX_ENTITIES : ID_SPACE;
  localparam int SlotW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  state_e              state_q, state_d;
  logic [SlotW-1:0]    clr_q, clr_d;
  func_e               op_q, op_d;
  logic [ENTITY_W-1:0] id_q, id_d;
  logic [CntW-1:0]     count_q, count_d;
  rsp_t                res_q, res_d;
  logic                fix_en_q, fix_en_d;
  logic [SlotW-1:0]    fix_addr_q, fix_addr_d;
  logic [SlotW-1:0]    fix_slot_q, fix_slot_d;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_q, out_d;

  logic                sp_we;
  logic [SlotW-1:0]    sp_waddr, sp_raddr;
  logic [SlotW:0]      sp_wdata, sp_rdata;
  logic                dn_we;
  logic [SlotW-1:0]    dn_waddr, dn_raddr;
  logic [ENTITY_W-1:0] dn_wdata, dn_rdata;

  logic [CntW-1:0]     cnt_m1;
  logic [SlotW-1:0]    last_slot;
  logic [SlotW-1:0]    slot;
  logic                in_range;
  logic                present;

  // Sparse table: a valid bit over a slot number, one entry per entity.
  ssim_ram #(.Width(SlotW + 1), .Depth(Depth)) u_sparse (
    .clk_i  (clk_i),
    .we_i   (sp_we),
    .waddr_i(sp_waddr),
    .wdata_i(sp_wdata),
    .raddr_i(sp_raddr),
    .rdata_o(sp_rdata)
  );

  // Dense table: the entity id held in each slot.
  ssim_ram #(.Width(ENTITY_W), .Depth(Depth)) u_dense (
    .clk_i  (clk_i),
    .we_i   (dn_we),
    .waddr_i(dn_waddr),
    .wdata_i(dn_wdata),
    .raddr_i(dn_raddr),
    .rdata_o(dn_rdata)
  );

  // Look-up terms shared by the sequencer.
  assign cnt_m1    = count_q - CntW'(1);
  assign last_slot = cnt_m1[SlotW-1:0];
  assign slot      = sp_rdata[SlotW-1:0];
  assign in_range  = (32'(id_q) < 32'(MAX_ENTITIES));
  assign present   = in_range && sp_rdata[SlotW];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Sequencer: next state, table accesses and the result.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    op_d        = op_q;
    id_d        = id_q;
    count_d     = count_q;
    res_d       = res_q;
    fix_en_d    = fix_en_q;
    fix_addr_d  = fix_addr_q;
    fix_slot_d  = fix_slot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    sp_we    = 1'b0;
    sp_waddr = id_q[SlotW-1:0];
    sp_wdata = '0;
    sp_raddr = in_item_i.entity_id[SlotW-1:0];
    dn_we    = 1'b0;
    dn_waddr = count_q[SlotW-1:0];
    dn_wdata = id_q;
    dn_raddr = last_slot;

    case (state_q)
      ST_CLEAR: begin
        sp_we    = 1'b1;
        sp_waddr = clr_q;
        sp_wdata = '0;
        clr_d    = clr_q + SlotW'(1);
        if (clr_q == SlotW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_item_i.func;
          id_d    = in_item_i.entity_id;
          state_d = ST_LOOK;
        end
      end

      ST_LOOK: begin
        fix_en_d                  = 1'b0;
        res_d.present             = present;
        res_d.dense_index         = present ? ENTITY_W'(slot) : '0;
        res_d.moved               = 1'b0;
        res_d.moved_from_index    = '0;
        res_d.moved_entity        = '0;
        res_d.live_count          = COUNT_W'(count_q);
        case (op_q)
          FN_ADD: begin
            if (!present && in_range && (count_q < CntW'(Depth))) begin
              sp_we             = 1'b1;
              sp_wdata          = {1'b1, count_q[SlotW-1:0]};
              dn_we             = 1'b1;
              count_d           = count_q + CntW'(1);
              res_d.dense_index = ENTITY_W'(count_q[SlotW-1:0]);
              res_d.live_count  = COUNT_W'(count_q + CntW'(1));
            end
          end
          FN_REMOVE: begin
            if (present) begin
              sp_we            = 1'b1;
              sp_wdata         = '0;
              count_d          = cnt_m1;
              res_d.live_count = COUNT_W'(cnt_m1);
              if (slot != last_slot) begin
                dn_we                  = 1'b1;
                dn_waddr               = slot;
                dn_wdata               = dn_rdata;
                fix_en_d               = 1'b1;
                fix_addr_d             = dn_rdata[SlotW-1:0];
                fix_slot_d             = slot;
                res_d.moved            = 1'b1;
                res_d.moved_from_index = ENTITY_W'(last_slot);
                res_d.moved_entity     = dn_rdata;
              end
            end
          end
          default: begin
          end
        endcase
        state_d = ST_FIX;
      end

      ST_FIX: begin
        // The moved entity now points at the freed slot.
        if (fix_en_q) begin
          sp_we    = 1'b1;
          sp_waddr = fix_addr_q;
          sp_wdata = {1'b1, fix_slot_q};
        end
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      fix_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      fix_en_q    <= fix_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    res_q      <= res_d;
    fix_addr_q <= fix_addr_d;
    fix_slot_q <= fix_slot_d;
    out_q      <= out_d;
  end

  // Checks on the sequencer and the member count.
  `SSIM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(Depth), "member count beyond capacity")
  `SSIM_ASSERT_NEXT(a_accept_look, in_valid_i && in_ready_o, state_q == ST_LOOK,
                    "accepted item did not enter the look-up")
  `SSIM_ASSERT_NEXT(a_remove_count, (state_q == ST_LOOK) && (op_q == FN_REMOVE) && present,
                    count_q == $past(count_q) - CntW'(1), "remove did not shrink the set")
  `SSIM_ASSERT_NOW(a_out_from_seq, $rose(out_valid_q), $past(state_q) == ST_OUT,
                   "result shown outside the output step")

endmodule
